// File: hdl/pdlr_pkg.sv
`default_nettype none
package pdlr_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int WORD_W    = 32;
  localparam int FMT_W     = 2;
  localparam int CNT_W     = 4;
  localparam int NCH_W     = CNT_W + 1;
  localparam int STEP_W    = 20;
  localparam int POS_W     = 20;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [POS_W-1:0]  ONE_Q16  = POS_W'(1 << FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(8192);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(786432);

  localparam logic [FMT_W-1:0] FMT_PCM16 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_PCM24 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_PCM32 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_FLT32 = 2'd3;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;

  localparam logic [FMT_W-1:0] FORMAT_RST = FMT_PCM16;
  localparam logic [CNT_W-1:0] COUNT_RST  = CNT_W'(1);
  localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'(65536);

  typedef struct packed {
    logic [WORD_W-1:0] sample_word;
    logic              end_of_stream;
  } pdlr_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       sample_valid;
    logic                       last;
  } pdlr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIV,
    ST_CUR,
    ST_LOOP,
    ST_INTERP,
    ST_TAIL,
    ST_TEMIT,
    ST_MARK
  } pdlr_state_t;

  typedef enum logic [1:0] {
    EMIT_INTERP,
    EMIT_HOLD,
    EMIT_MARK
  } pdlr_emit_t;

  typedef struct packed {
    logic       in_ready;
    logic       load_in;
    logic       accum;
    logic       div_step;
    logic       set_cur;
    logic       mul;
    logic       advance;
    logic       emit;
    pdlr_emit_t emit_sel;
    logic       clear;
  } pdlr_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic div_done;
    logic have_prev;
    logic eos;
    logic pos_lt_one;
    logic out_free;
    logic last_sent;
  } pdlr_stat_t;

endpackage
`default_nettype wire

// File: hdl/pdlr_ctrl.sv
`default_nettype none
module pdlr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pdlr_pkg::pdlr_stat_t stat,
  input  wire logic               in_valid,
  output pdlr_pkg::pdlr_cmd_t     cmd
);
  import pdlr_pkg::*;

  pdlr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (stat.frame_done) state_nxt = ST_DIV;
        else if (stat.eos) state_nxt = ST_TAIL;
        else state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (stat.div_done) state_nxt = ST_CUR;
      end
      ST_CUR: begin
        if (stat.have_prev) state_nxt = ST_LOOP;
        else if (stat.eos) state_nxt = ST_TAIL;
        else state_nxt = ST_IDLE;
      end
      ST_LOOP: begin
        if (stat.pos_lt_one) state_nxt = ST_INTERP;
        else if (stat.eos) state_nxt = ST_TAIL;
        else state_nxt = ST_IDLE;
      end
      ST_INTERP: begin
        if (stat.out_free) state_nxt = ST_LOOP;
      end
      ST_TAIL: begin
        if (stat.have_prev && stat.pos_lt_one) state_nxt = ST_TEMIT;
        else if (stat.last_sent) state_nxt = ST_IDLE;
        else state_nxt = ST_MARK;
      end
      ST_TEMIT: begin
        if (stat.out_free) state_nxt = ST_TAIL;
      end
      ST_MARK: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.emit_sel = EMIT_INTERP;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load_in  = in_valid;
      end
      ST_CONV: begin
        cmd.accum = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = !stat.div_done;
      end
      ST_CUR: begin
        cmd.set_cur = 1'b1;
      end
      ST_LOOP: begin
        cmd.mul     = stat.pos_lt_one;
        cmd.advance = !stat.pos_lt_one;
      end
      ST_INTERP: begin
        cmd.emit     = stat.out_free;
        cmd.emit_sel = EMIT_INTERP;
      end
      ST_TAIL: begin
        cmd.clear = !(stat.have_prev && stat.pos_lt_one) && stat.last_sent;
      end
      ST_TEMIT: begin
        cmd.emit     = stat.out_free;
        cmd.emit_sel = EMIT_HOLD;
      end
      ST_MARK: begin
        cmd.emit     = stat.out_free;
        cmd.emit_sel = EMIT_MARK;
        cmd.clear    = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/pdlr_dp.sv
`default_nettype none
module pdlr_dp #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pdlr_pkg::pdlr_cmd_t           cmd,
  output pdlr_pkg::pdlr_stat_t               stat,
  input  wire pdlr_pkg::pdlr_in_t            in_data,
  input  wire logic [pdlr_pkg::FMT_W-1:0]    cfg_format,
  input  wire logic [pdlr_pkg::CNT_W-1:0]    cfg_count,
  input  wire logic [pdlr_pkg::STEP_W-1:0]   cfg_step,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pdlr_pkg::pdlr_out_t                out_data
);
  import pdlr_pkg::*;

  localparam int SUMW = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int IDXW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DCW  = $clog2(SUMW + 1);
  localparam logic [NCH_W-1:0] MAXC = NCH_W'(MAX_CHANNELS);

  function automatic logic signed [SAMPLE_W-1:0] convert(
    input logic [FMT_W-1:0]  fmt,
    input logic [WORD_W-1:0] w
  );
    logic [7:0]          e;
    logic [7:0]          sh;
    logic [SAMPLE_W-1:0] mag;
    logic signed [SAMPLE_W-1:0] res;
    e   = w[30:23];
    sh  = 8'd127 - e;
    mag = {1'b1, w[22:0]};
    res = '0;
    unique case (fmt)
      FMT_PCM16: res = {w[15:0], 8'd0};
      FMT_PCM24: res = w[23:0];
      FMT_PCM32: res = w[31:8];
      FMT_FLT32: begin
        if (e == 8'hFF) begin
          if (w[22:0] != '0) res = '0;
          else res = w[31] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (e == 8'h00) begin
          res = '0;
        end else if (e >= 8'd127) begin
          res = w[31] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (sh >= 8'd32) begin
          res = '0;
        end else begin
          res = mag >> sh[4:0];
          if (w[31]) res = -res;
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  logic [WORD_W-1:0]          word_r;
  logic                       eos_r;
  logic [IDXW-1:0]            idx_r;
  logic signed [SUMW-1:0]     sum_r;
  logic [SUMW-1:0]            dvd_r;
  logic [NCH_W-1:0]           rem_r;
  logic                       neg_r;
  logic [DCW-1:0]             dcnt_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic                       have_prev_r;
  logic [POS_W-1:0]           pos_r;
  logic signed [41:0]         prod_r;
  logic                       last_sent_r;
  logic                       out_valid_r;
  pdlr_out_t                  out_r;

  logic [NCH_W-1:0]           n_ch;
  logic [STEP_W-1:0]          step_c;
  logic signed [SAMPLE_W-1:0] conv;
  logic signed [SUMW-1:0]     new_sum;
  logic [SUMW-1:0]            mag;
  logic [NCH_W:0]             trial;
  logic                       ge;
  logic signed [SAMPLE_W-1:0] q24;
  logic signed [SAMPLE_W-1:0] cur_c;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [FRAC_BITS:0]  frac;
  logic signed [41:0]         prod_c;
  logic [POS_W:0]             pos_sum;
  logic                       out_free;
  logic                       emit_last;
  pdlr_out_t                  emit_val;

  always_comb begin
    if (cfg_count == '0) n_ch = NCH_W'(1);
    else if ({1'b0, cfg_count} > MAXC) n_ch = MAXC;
    else n_ch = {1'b0, cfg_count};
  end

  always_comb begin
    if (cfg_step < STEP_MIN) step_c = STEP_MIN;
    else if (cfg_step > STEP_MAX) step_c = STEP_MAX;
    else step_c = cfg_step;
  end

  assign conv    = convert(cfg_format, word_r);
  assign new_sum = sum_r + SUMW'(conv);
  assign mag     = new_sum[SUMW-1] ? SUMW'(-new_sum) : SUMW'(new_sum);
  assign trial   = {rem_r, dvd_r[SUMW-1]} - {1'b0, n_ch};
  assign ge      = !trial[NCH_W];
  assign q24     = dvd_r[SAMPLE_W-1:0];
  assign cur_c   = neg_r ? -q24 : q24;
  assign diff    = {cur_r[SAMPLE_W-1], cur_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign frac    = {1'b0, pos_r[FRAC_BITS-1:0]};
  assign prod_c  = diff * frac;
  assign pos_sum = {1'b0, pos_r} + {1'b0, step_c};
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    emit_val  = '0;
    emit_last = 1'b0;
    unique case (cmd.emit_sel)
      EMIT_INTERP: begin
        emit_last = eos_r && (pos_sum >= {ONE_Q16, 1'b0});
        emit_val.out_sample   = prev_r + prod_r[SAMPLE_W+FRAC_BITS-1:FRAC_BITS];
        emit_val.sample_valid = 1'b1;
      end
      EMIT_HOLD: begin
        emit_last = pos_sum >= {1'b0, ONE_Q16};
        emit_val.out_sample   = prev_r;
        emit_val.sample_valid = 1'b1;
      end
      EMIT_MARK: begin
        emit_last = 1'b1;
      end
      default: emit_last = 1'b0;
    endcase
    emit_val.last = emit_last;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      word_r <= in_data.sample_word;
    end
    if (cmd.accum && stat.frame_done) begin
      dvd_r  <= mag;
      neg_r  <= new_sum[SUMW-1];
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[SUMW-2:0], ge};
      rem_r <= ge ? trial[NCH_W-1:0] : {rem_r[NCH_W-2:0], dvd_r[SUMW-1]};
    end
    if (cmd.set_cur) begin
      cur_r <= cur_c;
    end
    if (cmd.mul) begin
      prod_r <= prod_c;
    end
    if (cmd.emit) begin
      out_r <= emit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eos_r       <= 1'b0;
      idx_r       <= '0;
      sum_r       <= '0;
      dcnt_r      <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      pos_r       <= '0;
      last_sent_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        eos_r       <= in_data.end_of_stream;
        last_sent_r <= 1'b0;
      end
      if (cmd.accum) begin
        if (stat.frame_done) begin
          idx_r  <= '0;
          sum_r  <= '0;
          dcnt_r <= DCW'(SUMW);
        end else begin
          idx_r <= idx_r + 1'b1;
          sum_r <= new_sum;
        end
      end
      if (cmd.div_step) begin
        dcnt_r <= dcnt_r - 1'b1;
      end
      if (cmd.set_cur && !have_prev_r) begin
        prev_r      <= cur_c;
        have_prev_r <= 1'b1;
        pos_r       <= '0;
      end
      if (cmd.advance) begin
        pos_r  <= pos_r - ONE_Q16;
        prev_r <= cur_r;
      end
      if (cmd.emit) begin
        last_sent_r <= emit_last;
        if (cmd.emit_sel != EMIT_MARK) pos_r <= pos_sum[POS_W-1:0];
      end
      if (cmd.clear) begin
        idx_r       <= '0;
        sum_r       <= '0;
        prev_r      <= '0;
        have_prev_r <= 1'b0;
        pos_r       <= '0;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.frame_done = (NCH_W'(idx_r) + 1'b1) >= n_ch;
    stat.div_done   = (dcnt_r == '0);
    stat.have_prev  = have_prev_r;
    stat.eos        = eos_r;
    stat.pos_lt_one = (pos_r[POS_W-1:FRAC_BITS] == '0);
    stat.out_free   = out_free;
    stat.last_sent  = last_sent_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: hdl/pcm_downmix_linear_resampler.sv
// A word that closes a frame gives its first result after conversion, a bit-serial
// channel divider of 27 steps, then multiply.
// A new word is accepted only once the frame's results are out; the divider, the shared
// interpolation multiplier and output back-pressure all hold off input meanwhile.
// Reset: synchronous active-low rst_n returns config registers to defaults and clears state.
`default_nettype none
module pcm_downmix_linear_resampler #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire pdlr_pkg::pdlr_in_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output pdlr_pkg::pdlr_out_t                 out_data,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [pdlr_pkg::ADDR_W-1:0]    cfg_paddr,
  input  wire logic [pdlr_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [pdlr_pkg::DATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import pdlr_pkg::*;

  logic [FMT_W-1:0]  format_r;
  logic [CNT_W-1:0]  count_r;
  logic [STEP_W-1:0] step_r;
  logic              wr_en;
  pdlr_cmd_t         cmd;
  pdlr_stat_t        stat;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= FORMAT_RST;
      count_r  <= COUNT_RST;
      step_r   <= STEP_RST;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_FORMAT: format_r <= cfg_pwdata[FMT_W-1:0];
        REG_COUNT:  count_r  <= cfg_pwdata[CNT_W-1:0];
        REG_STEP:   step_r   <= cfg_pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_FORMAT: cfg_prdata = DATA_W'(format_r);
      REG_COUNT:  cfg_prdata = DATA_W'(count_r);
      REG_STEP:   cfg_prdata = DATA_W'(step_r);
      default:    cfg_prdata = '0;
    endcase
  end

  pdlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .in_valid (in_valid),
    .cmd      (cmd)
  );

  pdlr_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .cfg_format (format_r),
    .cfg_count  (count_r),
    .cfg_step   (step_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign in_ready = cmd.in_ready;

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pdlr_pkg::*;

  localparam int CH_LIMIT       = 8;
  localparam int SETTLE_CYCLES  = 64;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int PRINT_LIMIT    = 40;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  pdlr_in_t          in_data;
  logic              out_valid;
  logic              out_ready;
  pdlr_out_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  logic [FMT_W-1:0]  fmt_reg;
  logic [CNT_W-1:0]  count_reg;
  logic [STEP_W-1:0] step_reg;
  int unsigned       ch_idx;
  int                ch_sum;
  int                prev_mono;
  bit                have_prev;
  int unsigned       phase_pos;

  pdlr_out_t expected_samples[$];
  int        mismatches;
  int        words_sent;
  int        in_idle_pct;
  int        out_stall_pct;

  pcm_downmix_linear_resampler #(.MAX_CHANNELS(CH_LIMIT)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_word
    pdlr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(out_data), 32'd0);
      end else begin
        want = expected_samples.pop_front();
        if (out_data.out_sample !== want.out_sample)
          report_mismatch("out_sample", 32'(out_data.out_sample), 32'(want.out_sample));
        if (out_data.sample_valid !== want.sample_valid)
          report_mismatch("sample_valid", 32'(out_data.sample_valid),
                          32'(want.sample_valid));
        if (out_data.last !== want.last)
          report_mismatch("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  function automatic int float_to_q23(input logic [WORD_W-1:0] w);
    int unsigned mag;
    int          sh;
    if (w[30:23] == 8'hFF) begin
      if (w[22:0] != 23'd0)
        return 0;
      return w[31] ? -8388608 : 8388607;
    end
    if (w[30:23] == 8'h00) begin
      mag = w[22:0];
      sh  = 126;
    end else begin
      mag = {1'b1, w[22:0]};
      sh  = 127 - int'(w[30:23]);
    end
    if (sh <= 0)
      return w[31] ? -8388608 : 8388607;
    mag = (sh >= 32) ? 0 : (mag >> sh);
    return w[31] ? -int'(mag) : int'(mag);
  endfunction

  function automatic int to_q23(input logic [WORD_W-1:0] w);
    logic signed [15:0] s16;
    logic signed [23:0] s24;
    case (fmt_reg)
      FMT_PCM16: begin
        s16 = w[15:0];
        return int'(s16) * 256;
      end
      FMT_PCM24: begin
        s24 = w[23:0];
        return int'(s24);
      end
      FMT_PCM32: begin
        s24 = w[31:8];
        return int'(s24);
      end
      default: return float_to_q23(w);
    endcase
  endfunction

  function automatic int lerp_q16(input int a, input int b, input int unsigned frac);
    longint prod;
    prod = (longint'(b) - longint'(a)) * longint'(frac);
    return a + int'(prod >>> FRAC_BITS);
  endfunction

  function automatic int unsigned eff_channels();
    if (count_reg == 0)
      return 1;
    return (count_reg > CH_LIMIT) ? CH_LIMIT : count_reg;
  endfunction

  function automatic void downmix_resample(input logic [WORD_W-1:0] w, input logic eos);
    pdlr_out_t   burst [16];
    int unsigned nch;
    int unsigned stp;
    int          q;
    int          cur;
    int          n;
    int          i;
    n   = 0;
    nch = eff_channels();
    stp = (step_reg < STEP_MIN) ? STEP_MIN : ((step_reg > STEP_MAX) ? STEP_MAX : step_reg);
    ch_sum += to_q23(w);
    if (ch_idx + 1 >= nch) begin
      q   = ((ch_sum < 0) ? -ch_sum : ch_sum) / int'(nch);
      cur = (ch_sum < 0) ? -q : q;
      ch_idx = 0;
      ch_sum = 0;
      if (!have_prev) begin
        prev_mono = cur;
        have_prev = 1'b1;
        phase_pos = 0;
      end else begin
        while (phase_pos < ONE_Q16 && n < 16) begin
          burst[n] = {SAMPLE_W'(lerp_q16(prev_mono, cur, phase_pos)), 1'b1, 1'b0};
          n++;
          phase_pos += stp;
        end
        phase_pos -= ONE_Q16;
        prev_mono = cur;
      end
    end else begin
      ch_idx++;
    end
    if (eos) begin
      if (have_prev) begin
        while (phase_pos < ONE_Q16 && n < 16) begin
          burst[n] = {SAMPLE_W'(prev_mono), 1'b1, 1'b0};
          n++;
          phase_pos += stp;
        end
      end
      if (n > 0) begin
        burst[n-1].last = 1'b1;
      end else begin
        burst[0] = '0;
        burst[0].last = 1'b1;
        n = 1;
      end
      ch_idx    = 0;
      ch_sum    = 0;
      prev_mono = 0;
      have_prev = 1'b0;
      phase_pos = 0;
    end
    for (i = 0; i < n; i++)
      expected_samples.push_back(burst[i]);
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w, input logic eos);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = {w, eos};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    downmix_resample(w, eos);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_valid = 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = ADDR_W'({idx, 2'b00});
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_FORMAT: fmt_reg   = value[FMT_W-1:0];
      REG_COUNT:  count_reg = value[CNT_W-1:0];
      REG_STEP:   step_reg  = value[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic cfg_check(input logic [1:0] idx, input logic [DATA_W-1:0] want);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = ADDR_W'({idx, 2'b00});
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want)
      report_mismatch("register read", cfg_prdata, want);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_config(input logic [FMT_W-1:0] fmt, input logic [CNT_W-1:0] cnt,
                            input logic [STEP_W-1:0] stp);
    settle();
    cfg_write(REG_FORMAT, DATA_W'(fmt));
    cfg_write(REG_COUNT, DATA_W'(cnt));
    cfg_write(REG_STEP, DATA_W'(stp));
    cfg_check(REG_FORMAT, DATA_W'(fmt_reg));
    cfg_check(REG_COUNT, DATA_W'(count_reg));
    cfg_check(REG_STEP, DATA_W'(step_reg));
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    w = $urandom;
    if ($urandom_range(15) == 0) begin
      case ($urandom_range(7))
        0: w = 32'h0000_7FFF;
        1: w = 32'h0000_8000;
        2: w = 32'h007F_FFFF;
        3: w = 32'h0080_0000;
        4: w = 32'h7FFF_FFFF;
        5: w = 32'h8000_0000;
        6: w = 32'h7F80_0000;
        default: w = 32'hFF80_0000;
      endcase
    end else if (fmt_reg == FMT_FLT32 && $urandom_range(3) != 0) begin
      w[30:23] = 8'($urandom_range(96, 127));
    end
    return w;
  endfunction

  task automatic test_register_access();
    cfg_check(REG_FORMAT, DATA_W'(FORMAT_RST));
    cfg_check(REG_COUNT, DATA_W'(COUNT_RST));
    cfg_check(REG_STEP, DATA_W'(STEP_RST));
    set_config(FMT_FLT32, 4'd15, 20'hFFFFF);
    set_config(FMT_PCM24, 4'd0, 20'h00000);
  endtask

  task automatic test_pcm16_unit_step();
    set_config(FMT_PCM16, 4'd1, STEP_RST);
    send_word(32'h0000_7FFF, 1'b0);
    send_word(32'h1234_8000, 1'b0);
    send_word(32'hFFFF_0001, 1'b0);
    send_word(32'h0000_0000, 1'b1);
  endtask

  task automatic test_min_step_full_burst();
    set_config(FMT_PCM24, 4'd1, STEP_MIN);
    send_word(32'h007F_FFFF, 1'b0);
    send_word(32'hFF80_0000, 1'b1);
    set_config(FMT_PCM32, 4'd1, 20'h00000);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b1);
  endtask

  task automatic test_float_specials();
    set_config(FMT_FLT32, 4'd1, STEP_RST);
    send_word(32'h7F80_0000, 1'b0);
    send_word(32'hFF80_0000, 1'b0);
    send_word(32'h7FC0_0000, 1'b0);
    send_word(32'h3F80_0000, 1'b0);
    send_word(32'hBF80_0000, 1'b0);
    send_word(32'h3F00_0000, 1'b0);
    send_word(32'h807F_FFFF, 1'b0);
    send_word(32'hBF40_0000, 1'b1);
  endtask

  task automatic test_partial_frame_marker();
    set_config(FMT_PCM16, 4'd3, 20'hFFFFF);
    send_word(32'h0000_8000, 1'b0);
    send_word(32'h0000_8000, 1'b0);
    send_word(32'h0000_7FFE, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_FFFF, 1'b0);
    send_word(32'h0000_0002, 1'b0);
    send_word(32'h0000_1234, 1'b1);
  endtask

  task automatic test_count_lowered_mid_frame();
    set_config(FMT_PCM24, 4'd15, 20'h20000);
    send_word(32'h0040_0000, 1'b0);
    send_word(32'h00C0_0000, 1'b0);
    send_word(32'h0020_0000, 1'b0);
    set_config(FMT_PCM24, 4'd0, 20'h20000);
    send_word(32'h0010_0000, 1'b0);
    send_word(32'hFFF0_0000, 1'b1);
  endtask

  task automatic test_lone_end();
    set_config(FMT_PCM16, 4'd2, STEP_RST);
    send_word(32'h5555_AAAA, 1'b1);
  endtask

  task automatic run_stream();
    int unsigned nch;
    int          total;
    int          cut;
    int          pause_at;
    int          k;
    bit          leave_open;
    nch        = eff_channels();
    total      = $urandom_range(1, 6) * nch;
    cut        = total;
    leave_open = 1'b0;
    if (nch > 1 && $urandom_range(7) == 0)
      cut = total - $urandom_range(1, nch - 1);
    else if ($urandom_range(9) == 0)
      leave_open = 1'b1;
    pause_at = ($urandom_range(5) == 0) ? $urandom_range(cut - 1) : -1;
    for (k = 0; k < cut; k++) begin
      if (k == pause_at)
        wait_results();
      send_word(random_word(), (k == cut - 1) && !leave_open);
    end
  endtask

  task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                     input int n_words);
    int                target;
    logic [CNT_W-1:0]  cnt;
    logic [STEP_W-1:0] stp;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    target        = words_sent + n_words;
    while (words_sent < target) begin
      cnt = ($urandom_range(7) != 0) ? CNT_W'($urandom_range(1, 8))
                                     : CNT_W'($urandom_range(15));
      case ($urandom_range(5))
        0: stp = STEP_MIN;
        1: stp = STEP_MAX;
        2: stp = STEP_W'($urandom_range(8192, 65536));
        3: stp = STEP_W'($urandom_range(65536, 786432));
        4: stp = STEP_W'($urandom);
        default: stp = STEP_RST;
      endcase
      set_config(FMT_W'($urandom_range(3)), cnt, stp);
      run_stream();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    mismatches    = 0;
    words_sent    = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    fmt_reg       = FORMAT_RST;
    count_reg     = COUNT_RST;
    step_reg      = STEP_RST;
    ch_idx        = 0;
    ch_sum        = 0;
    prev_mono     = 0;
    have_prev     = 1'b0;
    phase_pos     = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_register_access();
    test_pcm16_unit_step();
    test_min_step_full_burst();
    test_float_specials();
    test_partial_frame_marker();
    test_count_lowered_mid_frame();
    test_lone_end();
    test_random_streams(0, 0, 110);
    test_random_streams(75, 0, 110);
    test_random_streams(0, 75, 110);
    test_random_streams(21, 21, 100);

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
